/* sv/btp_pkg.sv */
// package for the binary thread pruning block
// shared sizes, register addresses and column word type; no dependencies
package btp_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = 5;

    typedef logic [MAX_ROWS-1:0] col_word_t;

    // configuration register byte addresses
    typedef enum logic [ADDR_W-1:0] {
        REG_MIN_COUNT    = 5'd0,
        REG_MAX_PASSES   = 5'd4,
        REG_USE_DIAGONAL = 5'd8,
        REG_ROW_COUNT    = 5'd12,
        REG_COL_COUNT    = 5'd16,
        REG_ACTIVE_LEVEL = 5'd20
    } reg_addr_t;

endpackage

/* sv/btp_if.sv */
// valid/ready channel interfaces for pixel input and column result output
// depends on btp_pkg
interface btp_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_value;
    logic        last_pixel;
    modport source (output valid, pixel_value, last_pixel, input ready);
    modport sink   (input valid, pixel_value, last_pixel, output ready);
endinterface

interface btp_col_if;
    import btp_pkg::*;
    logic             valid;
    logic             ready;
    col_word_t        column_mask;
    logic [COL_W-1:0] column_index;
    logic             setting_error;
    logic             last_column;
    modport source (output valid, column_mask, column_index, setting_error, last_column,
                    input ready);
    modport sink   (input valid, column_mask, column_index, setting_error, last_column,
                    output ready);
endinterface

/* sv/btp_ram.sv */
// generic single write port ram with registered read
// no dependencies
module btp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/binary_thread_pruning_top.sv */
// binary thread pruning top level
// depends on btp_pkg, btp_if and btp_ram
//
// usage:
//   pixels arrive on pix_in in column-major order, one transfer per cycle
//   while loading. a pixel is active when its magnitude exceeds active_level.
//   the transfer with last_pixel set starts pruning, or output at once on a
//   setting error or a zero max_passes; pix_in.ready is low until every
//   column result has been taken. each pruning pass primes the column window
//   and then sweeps the active-map ram one column at a time; up to max_passes
//   passes run, fewer when a pass removes nothing.
//   results leave on col_out, one column per transfer; each column is read
//   from the thread-map ram and captured in the output register, and the
//   next is read only once it is taken; a stall on col_out simply holds it.
//   configuration is written through the apb port while idle.
//   reset (rst_n low) restores register defaults and empties the image;
//   the rams need no clearing pass, a fill count masks stale columns.
module binary_thread_pruning_top
    import btp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    btp_pix_if.sink           pix_in,
    btp_col_if.source         col_out
);

    typedef enum logic [3:0] {
        S_LOAD, S_PRIME, S_PRIME2, S_RD, S_PROC, S_NEXTPASS, S_ORD, S_OCAP, S_OWAIT
    } state_t;

    state_t state_reg;

    logic [3:0]  min_count_reg;
    logic [7:0]  max_passes_reg;
    logic        use_diagonal_reg;
    logic [6:0]  row_count_reg;
    logic [6:0]  col_count_reg;
    logic [14:0] active_level_reg;

    logic [ROW_W:0]   row_ld_reg;
    logic [COL_W:0]   col_ld_reg;
    logic [COL_W:0]   fill_reg;
    col_word_t        buf_reg;
    logic [COL_W-1:0] c_reg;
    logic [7:0]       pass_reg;
    logic             any_reg;
    logic             zero_reg;
    logic             err_reg;
    col_word_t        prev_reg;
    col_word_t        cur_reg;
    col_word_t        mask_out_reg;
    logic             valid_out_reg;
    logic             last_out_reg;

    // apb configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg    <= 4'd2;
            max_passes_reg   <= 8'd15;
            use_diagonal_reg <= 1'b0;
            row_count_reg    <= 7'd64;
            col_count_reg    <= 7'd64;
            active_level_reg <= 15'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                REG_MIN_COUNT:    min_count_reg    <= pwdata[3:0];
                REG_MAX_PASSES:   max_passes_reg   <= pwdata[7:0];
                REG_USE_DIAGONAL: use_diagonal_reg <= pwdata[0];
                REG_ROW_COUNT:    row_count_reg    <= pwdata[6:0];
                REG_COL_COUNT:    col_count_reg    <= pwdata[6:0];
                REG_ACTIVE_LEVEL: active_level_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_MIN_COUNT:    prdata = {28'd0, min_count_reg};
            REG_MAX_PASSES:   prdata = {24'd0, max_passes_reg};
            REG_USE_DIAGONAL: prdata = {31'd0, use_diagonal_reg};
            REG_ROW_COUNT:    prdata = {25'd0, row_count_reg};
            REG_COL_COUNT:    prdata = {25'd0, col_count_reg};
            REG_ACTIVE_LEVEL: prdata = {17'd0, active_level_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // clamped image size
    logic [6:0] rows;
    logic [6:0] cols;
    assign rows = (row_count_reg == 7'd0) ? 7'd1 :
                  (row_count_reg > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : row_count_reg;
    assign cols = (col_count_reg == 7'd0) ? 7'd1 :
                  (col_count_reg > 7'(MAX_COLS)) ? 7'(MAX_COLS) : col_count_reg;

    logic setting_err;
    assign setting_err = (min_count_reg == 4'd0) ||
                         (min_count_reg > (use_diagonal_reg ? 4'd8 : 4'd4));

    // pixel activity
    logic [16:0] pix_ext;
    logic [16:0] pix_mag;
    logic        pix_act;
    assign pix_ext = {pix_in.pixel_value[15], pix_in.pixel_value};
    assign pix_mag = pix_ext[16] ? (17'd0 - pix_ext) : pix_ext;
    assign pix_act = pix_mag > {2'b00, active_level_reg};

    logic pix_xfer;
    assign pix_in.ready = (state_reg == S_LOAD);
    assign pix_xfer     = pix_in.valid && pix_in.ready;

    logic      ld_in_range;
    logic      ld_col_end;
    col_word_t ld_buf_next;
    always_comb
    begin
        ld_in_range = (col_ld_reg < cols);
        ld_col_end  = (row_ld_reg + 7'd1 == rows);
        ld_buf_next = buf_reg;
        ld_buf_next[row_ld_reg[ROW_W-1:0]] = pix_act;
    end

    // column window and removal set
    logic [COL_W:0] c_next_ext;
    logic           c_is_last;
    col_word_t      a_rdata;
    col_word_t      t_rdata;
    col_word_t      nxt_col;
    col_word_t      rem;
    assign c_next_ext = {1'b0, c_reg} + 7'd1;
    assign c_is_last  = (c_next_ext == cols);
    assign nxt_col    = (c_next_ext < cols && c_next_ext < fill_reg) ? a_rdata : '0;

    always_comb
    begin
        logic [3:0] cnt;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            cnt = 4'd0;
            if (r > 0)
            begin
                cnt = cnt + 4'(cur_reg[r-1]);
            end
            if (r < MAX_ROWS - 1)
            begin
                cnt = cnt + 4'(cur_reg[r+1]);
            end
            cnt = cnt + 4'(prev_reg[r]) + 4'(nxt_col[r]);
            if (use_diagonal_reg)
            begin
                if (r > 0)
                begin
                    cnt = cnt + 4'(prev_reg[r-1]) + 4'(nxt_col[r-1]);
                end
                if (r < MAX_ROWS - 1)
                begin
                    cnt = cnt + 4'(prev_reg[r+1]) + 4'(nxt_col[r+1]);
                end
            end
            rem[r] = cur_reg[r] && (cnt < min_count_reg);
        end
    end

    // ram port muxing
    logic             a_we;
    logic [COL_W-1:0] a_waddr;
    col_word_t        a_wdata;
    logic [COL_W-1:0] a_raddr;
    logic             t_we;
    col_word_t        t_wdata;
    logic [COL_W-1:0] t_raddr;

    always_comb
    begin
        a_we    = 1'b0;
        a_waddr = c_reg;
        a_wdata = cur_reg & ~rem;
        t_we    = 1'b0;
        t_wdata = (pass_reg == 8'd0) ? rem : (t_rdata | rem);
        a_raddr = c_next_ext[COL_W-1:0];
        t_raddr = c_reg;
        case (state_reg)
            S_LOAD:
            begin
                a_we    = pix_xfer && ld_in_range && (ld_col_end || pix_in.last_pixel);
                a_waddr = col_ld_reg[COL_W-1:0];
                a_wdata = ld_buf_next;
            end
            S_PRIME:
            begin
                a_raddr = '0;
            end
            S_PROC:
            begin
                a_we = 1'b1;
                t_we = 1'b1;
            end
            default: ;
        endcase
    end

    btp_ram #(.WIDTH(MAX_ROWS), .DEPTH(MAX_COLS)) u_active_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    btp_ram #(.WIDTH(MAX_ROWS), .DEPTH(MAX_COLS)) u_thread_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (c_reg),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    col_word_t row_mask;
    assign row_mask = (rows == 7'(MAX_ROWS)) ? '1 : ((col_word_t'(1) << rows) - 1'b1);

    // control sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            row_ld_reg    <= '0;
            col_ld_reg    <= '0;
            fill_reg      <= '0;
            buf_reg       <= '0;
            c_reg         <= '0;
            pass_reg      <= '0;
            any_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            err_reg       <= 1'b0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            mask_out_reg  <= '0;
            valid_out_reg <= 1'b0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (pix_xfer)
                    begin
                        if (pix_in.last_pixel)
                        begin
                            if (ld_in_range)
                            begin
                                fill_reg <= col_ld_reg + 7'd1;
                            end
                            row_ld_reg <= '0;
                            col_ld_reg <= '0;
                            buf_reg    <= '0;
                            pass_reg   <= '0;
                            c_reg      <= '0;
                            err_reg    <= setting_err;
                            zero_reg   <= setting_err || (max_passes_reg == 8'd0);
                            if (setting_err || (max_passes_reg == 8'd0))
                            begin
                                state_reg <= S_ORD;
                            end
                            else
                            begin
                                state_reg <= S_PRIME;
                            end
                        end
                        else if (ld_in_range)
                        begin
                            if (ld_col_end)
                            begin
                                buf_reg    <= '0;
                                fill_reg   <= col_ld_reg + 7'd1;
                                row_ld_reg <= '0;
                                col_ld_reg <= col_ld_reg + 7'd1;
                            end
                            else
                            begin
                                buf_reg    <= ld_buf_next;
                                row_ld_reg <= row_ld_reg + 7'd1;
                            end
                        end
                    end
                end
                S_PRIME:
                begin
                    state_reg <= S_PRIME2;
                end
                S_PRIME2:
                begin
                    cur_reg   <= (fill_reg != '0) ? a_rdata : '0;
                    prev_reg  <= '0;
                    c_reg     <= '0;
                    any_reg   <= 1'b0;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_PROC;
                end
                S_PROC:
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= nxt_col;
                    any_reg  <= any_reg || (rem != '0);
                    if (c_is_last)
                    begin
                        fill_reg  <= cols;
                        pass_reg  <= pass_reg + 8'd1;
                        state_reg <= S_NEXTPASS;
                    end
                    else
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_NEXTPASS:
                begin
                    if (!any_reg || pass_reg == max_passes_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        state_reg <= S_PRIME;
                    end
                end
                S_ORD:
                begin
                    state_reg <= S_OCAP;
                end
                S_OCAP:
                begin
                    mask_out_reg  <= zero_reg ? '0 : (t_rdata & row_mask);
                    last_out_reg  <= c_is_last;
                    valid_out_reg <= 1'b1;
                    state_reg     <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    if (col_out.ready)
                    begin
                        valid_out_reg <= 1'b0;
                        if (last_out_reg)
                        begin
                            fill_reg  <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign col_out.valid         = valid_out_reg;
    assign col_out.column_mask   = mask_out_reg;
    assign col_out.column_index  = c_reg;
    assign col_out.setting_error = err_reg;
    assign col_out.last_column   = last_out_reg;

endmodule

/* sv/btp_checker.sv */
// port-level checker for the binary thread pruning block, with its bind
// depends on btp_pkg and binary_thread_pruning_top
module btp_checker
    import btp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input col_word_t        out_mask,
    input logic [COL_W-1:0] out_index,
    input logic             out_err,
    input logic             out_last
);

    // a stalled result stays valid and keeps its column index
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index))
        else $error("stalled result changed");

    // no pixel taken while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid)
        else $error("input open while result pending");

    // a setting error always gives an empty mask
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> out_mask == '0)
        else $error("error result with nonzero mask");

    // columns go up by one within an image
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_index == $past(out_index) + 1'b1)
        else $error("column order broken");

endmodule

bind binary_thread_pruning_top btp_checker u_btp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (col_out.valid),
    .out_ready (col_out.ready),
    .out_mask  (col_out.column_mask),
    .out_index (col_out.column_index),
    .out_err   (col_out.setting_error),
    .out_last  (col_out.last_column)
);
